// File: sv/stdf_pkg.sv
// security table deframer: shared types and constants
// no dependencies; used by the interfaces, the size store and the top level
`default_nettype none

package stdf_pkg;

    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int ALIGNED_W  = 33;
    localparam int SIZE_W     = 32;
    localparam int LENGTH_W   = 32;
    localparam int RUNNING_W  = 35;

    localparam logic [1:0] STATUS_VALID    = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic KIND_DESC   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [31:0] COUNT_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [2:0]  LAST_FIELD_BYTE = 3'd7;

    typedef struct packed {
        logic                  kind;
        logic [BYTE_W-1:0]     out_byte;
        logic [INDEX_W-1:0]    entry_index;
        logic                  entry_end;
        logic [STATUS_W-1:0]   status;
        logic                  length_mismatch;
        logic [ALIGNED_W-1:0]  aligned_length;
        logic                  last;
    } t_result;

endpackage

`default_nettype wire

// File: sv/stdf_if.sv
// security table deframer: input and output channel interfaces
// depends on stdf_pkg for field widths
`default_nettype none

interface stdf_in_if;
    logic                        valid;
    logic                        ready;
    logic [stdf_pkg::BYTE_W-1:0] in_byte;
    logic                        first;

    modport source (output valid, output in_byte, output first, input ready);
    modport sink   (input valid, input in_byte, input first, output ready);
endinterface

interface stdf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [stdf_pkg::BYTE_W-1:0]    out_byte;
    logic [stdf_pkg::INDEX_W-1:0]   entry_index;
    logic                           entry_end;
    logic [stdf_pkg::STATUS_W-1:0]  status;
    logic                           length_mismatch;
    logic [stdf_pkg::ALIGNED_W-1:0] aligned_length;
    logic                           last;

    modport source (output valid, output kind, output out_byte, output entry_index,
                    output entry_end, output status, output length_mismatch,
                    output aligned_length, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input entry_index,
                    input entry_end, input status, input length_mismatch,
                    input aligned_length, input last, output ready);
endinterface

`default_nettype wire

// File: sv/stdf_size_store.sv
// security table deframer: entry size memory, one write and one read port
// read data registered, write data forwarded on a same-address read; uses stdf_pkg
`default_nettype none

module stdf_size_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [stdf_pkg::SIZE_W-1:0]   i_wdata,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [stdf_pkg::SIZE_W-1:0]   o_rdata
);

    logic [stdf_pkg::SIZE_W-1:0] r_mem [DEPTH];
    logic [stdf_pkg::SIZE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/security_table_deframer.sv
// security table deframer: top level, parse control and result register
// depends on stdf_pkg, stdf_in_if, stdf_out_if and stdf_size_store
//
// Usage:
//   i_in carries one resource byte per beat; first marks the opening byte of a
//   resource and restarts the parse. o_out carries results: descriptor bytes
//   tagged with their entry index, then one status beat per resource. The user
//   must load the resource length via i_cfg_we / i_cfg_wdata only while the
//   block is idle; the block itself does not enforce this.
// Throughput:
//   at most one byte per cycle, while the output register is free and no walk
//   runs; a result loads into the output register as its byte is accepted.
//   After the last size byte and each final descriptor byte, input is held off
//   to walk the size store over zero-size entries; a held byte then loads.
// Stall:
//   o_out has a single output register; while it holds an untaken beat no new
//   byte is accepted and the walk does not resolve.
// Reset:
//   parse returns to idle, resource length clears to 0; the size store keeps
//   its contents, every entry being written before it is read
`default_nettype none

module security_table_deframer #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    stdf_in_if.sink           i_in,
    stdf_out_if.source        o_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_SIZES,
        ST_DESC,
        ST_SCAN,
        ST_EMIT,
        ST_DONE
    } t_state;

    function automatic stdf_pkg::t_result f_desc(
        input logic [7:0] b,
        input logic [9:0] idx,
        input logic       ent_end,
        input logic       lst
    );
        stdf_pkg::t_result res;
        res                 = '0;
        res.kind            = stdf_pkg::KIND_DESC;
        res.out_byte        = b;
        res.entry_index     = idx;
        res.entry_end       = ent_end;
        res.status          = stdf_pkg::STATUS_VALID;
        res.last            = lst;
        return res;
    endfunction

    function automatic stdf_pkg::t_result f_fail(input logic [1:0] st);
        stdf_pkg::t_result res;
        res        = '0;
        res.kind   = stdf_pkg::KIND_STATUS;
        res.status = st;
        res.last   = 1'b1;
        return res;
    endfunction

    function automatic stdf_pkg::t_result f_finish(
        input logic [34:0] rt,
        input logic [31:0] decl,
        input logic [31:0] rl
    );
        logic [35:0]       calc;
        logic [32:0]       decl_al;
        stdf_pkg::t_result res;
        calc                = (36'(rt) + 36'd7) & ~36'd7;
        decl_al             = (33'(decl) + 33'd7) & ~33'd7;
        res                 = '0;
        res.kind            = stdf_pkg::KIND_STATUS;
        res.status          = (decl_al > 33'(rl)) ? stdf_pkg::STATUS_INVALID
                                                  : stdf_pkg::STATUS_VALID;
        res.length_mismatch = (calc != 36'(decl_al));
        res.aligned_length  = decl_al;
        res.last            = 1'b1;
        return res;
    endfunction

    t_state             r_state, n_state;
    logic [31:0]        r_rl;
    logic [2:0]         r_cnt, n_cnt;
    logic [7:0]         r_acc [7];
    logic [31:0]        r_decl, n_decl;
    logic [PW-1:0]      r_total, n_total;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [31:0]        r_left, n_left;
    logic [34:0]        r_rt, n_rt;
    logic               r_pend_valid, n_pend_valid;
    logic [7:0]         r_pend_byte, n_pend_byte;
    logic [9:0]         r_pend_idx, n_pend_idx;
    stdf_pkg::t_result  r_st, n_st;
    stdf_pkg::t_result  r_out, n_out;
    logic               r_out_valid;

    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               acc_we;
    logic [2:0]         fb;
    logic               is_hdr;
    logic [31:0]        v_hi;
    logic [31:0]        v_lo;
    logic [31:0]        hdr_decl;
    logic [34:0]        hdr_need;
    logic [PW-1:0]      ptr_inc;
    logic [31:0]        left_dec;
    logic [34:0]        scan_sum;
    logic               resolve;
    stdf_pkg::t_result  res;
    logic               mem_we;
    logic [31:0]        rd_data;

    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = out_free && (r_state == ST_IDLE || r_state == ST_HEADER
                        || r_state == ST_SIZES || r_state == ST_DESC
                        || r_state == ST_DONE);
    assign in_acc = i_in.valid && i_in.ready;

    assign fb       = i_in.first ? 3'd0 : r_cnt;
    assign is_hdr   = i_in.first || (r_state == ST_HEADER);
    assign v_hi     = {i_in.in_byte, r_acc[6], r_acc[5], r_acc[4]};
    assign v_lo     = {r_acc[3], r_acc[2], r_acc[1], r_acc[0]};
    assign hdr_decl = (v_lo == 32'd0) ? stdf_pkg::HEADER_BYTES : v_lo;
    assign hdr_need = 35'(stdf_pkg::HEADER_BYTES) + {v_hi, 3'b000};
    assign ptr_inc  = r_ptr + PW'(1);
    assign left_dec = (r_left != 32'd0) ? (r_left - 32'd1) : r_left;
    assign scan_sum = r_rt + 35'(rd_data);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_decl       = r_decl;
        n_total      = r_total;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_rt         = r_rt;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_idx   = r_pend_idx;
        n_st         = r_st;
        n_out        = r_out;
        out_load     = 1'b0;
        acc_we       = 1'b0;
        mem_we       = 1'b0;
        resolve      = 1'b0;
        res          = r_st;

        if (in_acc) begin
            if (i_in.first && (r_rl < stdf_pkg::HEADER_BYTES)) begin
                out_load = 1'b1;
                n_out    = f_fail(stdf_pkg::STATUS_INVALID);
                n_state  = ST_DONE;
            end else if (i_in.first || r_state == ST_HEADER || r_state == ST_SIZES) begin
                acc_we = (fb != stdf_pkg::LAST_FIELD_BYTE);
                n_cnt  = fb + 3'd1;
                if (i_in.first) begin
                    n_state = ST_HEADER;
                    n_ptr   = '0;
                end
                if (fb == stdf_pkg::LAST_FIELD_BYTE) begin
                    if (is_hdr) begin
                        n_decl = hdr_decl;
                        if (v_hi > stdf_pkg::COUNT_LIMIT || hdr_decl > r_rl
                                || hdr_need > 35'(hdr_decl)) begin
                            out_load = 1'b1;
                            n_out    = f_fail(stdf_pkg::STATUS_INVALID);
                            n_state  = ST_DONE;
                        end else if (v_hi > 32'(MAX_ENTRIES)) begin
                            out_load = 1'b1;
                            n_out    = f_fail(stdf_pkg::STATUS_OVERFLOW);
                            n_state  = ST_DONE;
                        end else begin
                            n_total = PW'(v_hi);
                            n_ptr   = '0;
                            n_rt    = hdr_need;
                            if (v_hi == 32'd0) begin
                                out_load = 1'b1;
                                n_out    = f_finish(hdr_need, hdr_decl, r_rl);
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_SIZES;
                            end
                        end
                    end else if (v_hi != 32'd0) begin
                        out_load = 1'b1;
                        n_out    = f_fail(stdf_pkg::STATUS_INVALID);
                        n_state  = ST_DONE;
                    end else begin
                        mem_we = 1'b1;
                        if (ptr_inc >= r_total) begin
                            n_ptr        = '0;
                            n_pend_valid = 1'b0;
                            n_state      = ST_SCAN;
                        end else begin
                            n_ptr = ptr_inc;
                        end
                    end
                end
            end else if (r_state == ST_DESC) begin
                n_left = left_dec;
                if (left_dec != 32'd0) begin
                    out_load = 1'b1;
                    n_out    = f_desc(i_in.in_byte, 10'(r_ptr), 1'b0, 1'b1);
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend_byte  = i_in.in_byte;
                    n_pend_idx   = 10'(r_ptr);
                    n_ptr        = ptr_inc;
                    n_state      = ST_SCAN;
                end
            end
        end else begin
            unique case (r_state)
                ST_SCAN: begin
                    if (r_ptr >= r_total) begin
                        if (out_free) begin
                            resolve = 1'b1;
                            res     = f_finish(r_rt, r_decl, r_rl);
                        end
                    end else if (rd_data == 32'd0) begin
                        n_ptr = ptr_inc;
                    end else if (out_free) begin
                        if (scan_sum > 35'(r_decl)) begin
                            resolve = 1'b1;
                            res     = f_fail(stdf_pkg::STATUS_INVALID);
                        end else begin
                            n_rt    = scan_sum;
                            n_left  = rd_data;
                            n_state = ST_DESC;
                            if (r_pend_valid) begin
                                out_load = 1'b1;
                                n_out    = f_desc(r_pend_byte, r_pend_idx, 1'b1, 1'b1);
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_out    = r_st;
                        n_state  = ST_DONE;
                    end
                end
                default: begin
                end
            endcase
            if (resolve) begin
                out_load = 1'b1;
                if (r_pend_valid) begin
                    n_out   = f_desc(r_pend_byte, r_pend_idx, 1'b1, 1'b0);
                    n_st    = res;
                    n_state = ST_EMIT;
                end else begin
                    n_out   = res;
                    n_state = ST_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rl         <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) begin
                r_rl <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cnt       <= n_cnt;
        r_decl      <= n_decl;
        r_total     <= n_total;
        r_ptr       <= n_ptr;
        r_left      <= n_left;
        r_rt        <= n_rt;
        r_pend_byte <= n_pend_byte;
        r_pend_idx  <= n_pend_idx;
        r_st        <= n_st;
        r_out       <= n_out;
        if (acc_we) begin
            r_acc[fb] <= i_in.in_byte;
        end
    end

    stdf_size_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_size_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ptr[AW-1:0]),
        .i_wdata (v_lo),
        .i_raddr (n_ptr[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.out_byte        = r_out.out_byte;
    assign o_out.entry_index     = r_out.entry_index;
    assign o_out.entry_end       = r_out.entry_end;
    assign o_out.status          = r_out.status;
    assign o_out.length_mismatch = r_out.length_mismatch;
    assign o_out.aligned_length  = r_out.aligned_length;
    assign o_out.last            = r_out.last;

`ifndef ASSERT_OFF
    a_emit_holds_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_out_valid)
        else $error("status pending with empty output register");

    a_scan_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_ptr <= r_total))
        else $error("size walk ran past entry count");

    a_desc_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DESC) |-> (r_left != 32'd0))
        else $error("descriptor phase with no bytes left");

    a_status_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.kind == stdf_pkg::KIND_DESC && !o_out.last)
        |=> (o_out.valid && o_out.kind == stdf_pkg::KIND_STATUS))
        else $error("status beat did not follow final descriptor byte");
`endif

endmodule

`default_nettype wire
